/* hw/rtl/ring_deque_with_cursor_assert.svh */
// Assertion macros shared by the ring deque RTL.
// Expects i_clk and i_rst_n in the scope where a macro is used.
`ifndef RING_DEQUE_WITH_CURSOR_ASSERT_SVH
`define RING_DEQUE_WITH_CURSOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define RDQ_ASSERT_IMP(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define RDQ_ASSERT_NXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

/* hw/rtl/rdq_pkg.sv */
// Package for the ring deque: sizes, operation and status codes, store request type.
// Used by rdq_store and ring_deque_with_cursor; depends on nothing.
`timescale 1ns / 1ps

package rdq_pkg;

    localparam int DEPTH  = 64;
    localparam int DATA_W = 32;
    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = PTR_W + 1;

    localparam int OP_W       = 4;
    localparam int DIN_W      = 32;
    localparam int DOUT_W     = 32;
    localparam int STAT_W     = 2;
    localparam int IN_FLD_W   = OP_W + DIN_W;
    localparam int IN_TDATA_W = ((IN_FLD_W + 7) / 8) * 8;
    localparam int OUT_FLD_W  = DOUT_W + STAT_W + CNT_W;
    localparam int OUT_TDATA_W = ((OUT_FLD_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 4'd0,
        OP_PUSH_BACK  = 4'd1,
        OP_POP_FRONT  = 4'd2,
        OP_POP_BACK   = 4'd3,
        OP_FIRST      = 4'd4,
        OP_LAST       = 4'd5,
        OP_NEXT       = 4'd6,
        OP_PREV       = 4'd7,
        OP_GET        = 4'd8,
        OP_CLEAR      = 4'd9
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic              we;
        logic [PTR_W-1:0]  waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [PTR_W-1:0]  raddr;
    } t_store_req;

    // Ring slot that follows slot i.
    function automatic logic [PTR_W-1:0] slot_inc(input logic [PTR_W-1:0] i);
        return (i == PTR_W'(DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    // Ring slot that precedes slot i.
    function automatic logic [PTR_W-1:0] slot_dec(input logic [PTR_W-1:0] i);
        return (i == '0) ? PTR_W'(DEPTH - 1) : i - 1'b1;
    endfunction

    // Physical slot of logical position pos counted from base.
    function automatic logic [PTR_W-1:0] slot_add(input logic [PTR_W-1:0] base,
                                                  input logic [CNT_W-1:0] pos);
        logic [SUM_W-1:0] s;
        s = SUM_W'(base) + SUM_W'(pos);
        if (s >= SUM_W'(DEPTH)) begin
            s = s - SUM_W'(DEPTH);
        end
        return s[PTR_W-1:0];
    endfunction

endpackage

/* hw/rtl/rdq_store.sv */
// Entry store of the ring deque: one write port and one read port, read data registered.
// Depends on rdq_pkg for sizes and the request struct.
`timescale 1ns / 1ps

module rdq_store
    import rdq_pkg::*;
(
    input  logic              i_clk,
    input  t_store_req        i_req,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // The read data holds until the next read, so a stalled result keeps its word.
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rd_data <= r_mem[i_req.raddr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hw/rtl/ring_deque_with_cursor.sv */
// Bounded double-ended queue with a circular cursor, kept in a ring store.
// Usage: each word on the slave stream carries one operation (push or pop at
// either end, place the cursor on the first or last entry, step it forward or
// back with wrap-around, read the entry under it, or clear). The master stream
// returns exactly one word per operation, in order: the data word (popped or
// under the cursor, zero otherwise), a status (ok, empty or no cursor, full)
// and the entry count after the operation.
// The result is registered and appears in the cycle after its word is accepted.
// Throughput is one operation per cycle unless the receiver stalls; the pointer
// update, one store write or read and the result register finish on acceptance.
// A stalled receiver is absorbed by the result register: a new operation is
// still taken in the cycle in which the pending result is taken, and input is
// held off only while a result waits and the receiver is not ready.
// Reset (synchronous, active low) empties the queue and drops the cursor;
// the store itself is not cleared, since only pushed entries are ever read.
// Depends on rdq_pkg, rdq_store and ring_deque_with_cursor_assert.svh.
`timescale 1ns / 1ps
`include "ring_deque_with_cursor_assert.svh"

module ring_deque_with_cursor
    import rdq_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // Fields from bit 0 up: op (4), data_in (32), zero padding.
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // Fields from bit 0 up: data_out (32), status (2), count (7), zero padding.
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // Queue state.
    logic [PTR_W-1:0] r_head, n_head;
    logic [CNT_W-1:0] r_count, n_count;
    logic [PTR_W-1:0] r_cur, n_cur;
    logic             r_cv, n_cv;

    // Result register.
    logic             r_out_valid;
    t_status          r_out_status, n_status;
    logic [CNT_W-1:0] r_out_count;
    logic             r_out_has_data, n_has_data;

    logic             w_acc;
    t_op              w_op;
    logic [DIN_W-1:0] w_din;
    logic             w_empty, w_full;
    logic [PTR_W-1:0] w_tail, w_head_inc, w_head_dec;
    t_store_req       w_req;
    logic [DATA_W-1:0] w_rd_data;
    logic [DOUT_W-1:0] w_dout;

    // Terms used by the checks at the end of the module.
    logic                 w_full_push;
    logic                 w_full_flagged;
    logic                 w_count_move;
    logic                 w_count_step_ok;
    logic [CNT_W+PTR_W:0] w_state;

    // A new word goes in whenever the result register is free or being emptied.
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_acc         = s_axis_tvalid && s_axis_tready;

    assign w_op  = t_op'(s_axis_tdata[OP_W-1:0]);
    assign w_din = s_axis_tdata[OP_W +: DIN_W];

    assign w_empty    = (r_count == '0);
    assign w_full     = (r_count == CNT_W'(DEPTH));
    assign w_tail     = slot_add(r_head, r_count - 1'b1);
    assign w_head_inc = slot_inc(r_head);
    assign w_head_dec = slot_dec(r_head);

    // Next state and store access for the operation on the input.
    always_comb begin
        n_head     = r_head;
        n_count    = r_count;
        n_cur      = r_cur;
        n_cv       = r_cv;
        n_status   = ST_OK;
        n_has_data = 1'b0;
        w_req.we    = 1'b0;
        w_req.waddr = r_head;
        w_req.wdata = DATA_W'(w_din);
        w_req.re    = 1'b0;
        w_req.raddr = r_head;

        case (w_op)
            OP_PUSH_FRONT: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_head      = w_head_dec;
                    w_req.we    = 1'b1;
                    w_req.waddr = w_head_dec;
                    n_count     = r_count + 1'b1;
                end
            end
            OP_PUSH_BACK: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_req.we    = 1'b1;
                    w_req.waddr = slot_add(r_head, r_count);
                    n_count     = r_count + 1'b1;
                end
            end
            OP_POP_FRONT: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    w_req.re    = 1'b1;
                    w_req.raddr = r_head;
                    n_has_data  = 1'b1;
                    // Popping the entry under the cursor drops the cursor.
                    if (r_cv && r_cur == r_head) begin
                        n_cv = 1'b0;
                    end
                    n_head  = w_head_inc;
                    n_count = r_count - 1'b1;
                end
            end
            OP_POP_BACK: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    w_req.re    = 1'b1;
                    w_req.raddr = w_tail;
                    n_has_data  = 1'b1;
                    if (r_cv && r_cur == w_tail) begin
                        n_cv = 1'b0;
                    end
                    n_count = r_count - 1'b1;
                end
            end
            OP_FIRST, OP_LAST: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_cur       = (w_op == OP_FIRST) ? r_head : w_tail;
                    n_cv        = 1'b1;
                    w_req.re    = 1'b1;
                    w_req.raddr = n_cur;
                    n_has_data  = 1'b1;
                end
            end
            OP_NEXT, OP_PREV, OP_GET: begin
                if (!r_cv || w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    // Stepping past either end wraps to the other end.
                    if (w_op == OP_NEXT) begin
                        n_cur = (r_cur == w_tail) ? r_head : slot_inc(r_cur);
                    end else if (w_op == OP_PREV) begin
                        n_cur = (r_cur == r_head) ? w_tail : slot_dec(r_cur);
                    end
                    w_req.re    = 1'b1;
                    w_req.raddr = n_cur;
                    n_has_data  = 1'b1;
                end
            end
            OP_CLEAR: begin
                n_head  = '0;
                n_count = '0;
                n_cv    = 1'b0;
            end
            default: begin
                // Unused codes leave everything as it is.
            end
        endcase

        // Nothing touches the store unless the word is actually taken.
        w_req.we = w_req.we && w_acc;
        w_req.re = w_req.re && w_acc;
    end

    rdq_store u_store (
        .i_clk     (i_clk),
        .i_req     (w_req),
        .o_rd_data (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_cur       <= '0;
            r_cv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_acc) begin
                r_head      <= n_head;
                r_count     <= n_count;
                r_cur       <= n_cur;
                r_cv        <= n_cv;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload; the store's read register supplies the data word.
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_out_status   <= n_status;
            r_out_count    <= n_count;
            r_out_has_data <= n_has_data;
        end
    end

    assign w_dout        = r_out_has_data ? DOUT_W'(w_rd_data) : '0;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'({r_out_count, r_out_status, w_dout});

    assign w_full_push     = w_acc && w_full
                             && (w_op == OP_PUSH_FRONT || w_op == OP_PUSH_BACK);
    assign w_full_flagged  = (r_out_status == ST_FULL) && w_full;
    assign w_count_move    = w_acc && (w_op != OP_CLEAR);
    assign w_count_step_ok = (n_count == r_count) || (n_count == r_count + 1'b1)
                             || (n_count == r_count - 1'b1);
    assign w_state         = {r_count, r_head, r_cv};

    `RDQ_ASSERT_IMP(a_cursor_needs_entries, r_cv, r_count != '0, "cursor valid on empty queue")
    `RDQ_ASSERT_NXT(a_full_push_flagged, w_full_push, w_full_flagged, "full push not flagged")
    `RDQ_ASSERT_IMP(a_count_single_step, w_count_move, w_count_step_ok, "count jumped")
    `RDQ_ASSERT_NXT(a_idle_state_holds, !w_acc, $stable(w_state), "state changed while idle")

endmodule

/* dv/tb_ring_deque_with_cursor.sv */
// Self-checking testbench for ring_deque_with_cursor. A scoreboard predicts
// every result word from its own copy of the deque and cursor state.
// Depends on rdq_pkg and the ring_deque_with_cursor RTL.
`timescale 1ns / 1ps

module tb_ring_deque_with_cursor;
    import rdq_pkg::*;

    // Codes 10 to 15 decode to no operation.
    localparam logic [OP_W-1:0]  OP_UNDEF_LO = 4'd10;
    localparam logic [OP_W-1:0]  OP_UNDEF_HI = 4'd15;
    localparam logic [DIN_W-1:0] WORD_ONES   = {DIN_W{1'b1}};
    // Cycles without any handshake before the run is declared hung.
    localparam int STUCK_LIMIT = 2000;

    typedef struct packed {
        logic [DOUT_W-1:0] data;
        t_status           status;
        logic [CNT_W-1:0]  count;
    } t_deque_result;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // Fields from bit 0 up: op (4), data_in (32), zero padding.
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // Fields from bit 0 up: data_out (32), status (2), count (7), zero padding.
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int err_count = 0;
    int stuck_cycles = 0;

    t_deque_result pending_results[$];

    // Shadow copy of the deque: ring store, front slot, fill level, cursor.
    logic [DATA_W-1:0] shadow_store[DEPTH];
    int                shadow_head = 0;
    int                shadow_count = 0;
    int                shadow_cursor = 0;
    bit                shadow_cursor_ok = 1'b0;

    ring_deque_with_cursor dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Applies one operation to the shadow deque and returns the word the
    // block must answer with.
    function automatic t_deque_result predict_deque_result(input logic [OP_W-1:0] op,
                                                           input logic [DIN_W-1:0] din);
        t_deque_result res;
        int            slot;
        int            tail;
        res.data   = '0;
        res.status = ST_OK;
        tail = (shadow_head + shadow_count + DEPTH - 1) % DEPTH;
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (shadow_count >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    if (op == OP_PUSH_FRONT) begin
                        shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
                        slot = shadow_head;
                    end else begin
                        slot = (shadow_head + shadow_count) % DEPTH;
                    end
                    shadow_store[slot] = DATA_W'(din);
                    shadow_count++;
                end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
                if (shadow_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    slot = (op == OP_POP_FRONT) ? shadow_head : tail;
                    res.data = DOUT_W'(shadow_store[slot]);
                    // Removing the entry under the cursor drops the cursor.
                    if (shadow_cursor_ok && shadow_cursor == slot) begin
                        shadow_cursor_ok = 1'b0;
                    end
                    if (op == OP_POP_FRONT) begin
                        shadow_head = (shadow_head + 1) % DEPTH;
                    end
                    shadow_count--;
                end
            end
            OP_FIRST, OP_LAST: begin
                if (shadow_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    shadow_cursor = (op == OP_FIRST) ? shadow_head : tail;
                    shadow_cursor_ok = 1'b1;
                    res.data = DOUT_W'(shadow_store[shadow_cursor]);
                end
            end
            OP_NEXT, OP_PREV, OP_GET: begin
                if (!shadow_cursor_ok || shadow_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    // Stepping wraps from the last entry to the first and back.
                    if (op == OP_NEXT) begin
                        shadow_cursor = (shadow_cursor == tail) ? shadow_head
                                                                : (shadow_cursor + 1) % DEPTH;
                    end else if (op == OP_PREV) begin
                        shadow_cursor = (shadow_cursor == shadow_head)
                                        ? tail : (shadow_cursor + DEPTH - 1) % DEPTH;
                    end
                    res.data = DOUT_W'(shadow_store[shadow_cursor]);
                end
            end
            OP_CLEAR: begin
                shadow_head = 0;
                shadow_count = 0;
                shadow_cursor_ok = 1'b0;
            end
            default: begin
            end
        endcase
        res.count = CNT_W'(shadow_count);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [DOUT_W-1:0] got,
                                   input logic [DOUT_W-1:0] want);
        $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    // Predicts on every accepted operation word and checks every accepted
    // result word against the oldest prediction. The prediction is queued
    // first so that a same-edge result still finds it.
    always @(posedge i_clk) begin : scoreboard
        t_deque_result got;
        t_deque_result want;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            pending_results.push_back(predict_deque_result(s_axis_tdata[OP_W-1:0],
                                                           s_axis_tdata[OP_W +: DIN_W]));
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.data   = m_axis_tdata[DOUT_W-1:0];
            got.status = t_status'(m_axis_tdata[DOUT_W +: STAT_W]);
            got.count  = m_axis_tdata[DOUT_W+STAT_W +: CNT_W];
            if (pending_results.size() == 0) begin
                report_mismatch("result word with nothing pending", got.data, '0);
            end else begin
                want = pending_results.pop_front();
                if (got.data !== want.data) begin
                    report_mismatch("data_out", got.data, want.data);
                end
                if (got.status !== want.status) begin
                    report_mismatch("status", DOUT_W'(got.status), DOUT_W'(want.status));
                end
                if (got.count !== want.count) begin
                    report_mismatch("count", DOUT_W'(got.count), DOUT_W'(want.count));
                end
            end
        end
    end

    // Receiver: ready drops at random at the rate of the current phase.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog on cycles in which no word moves on either side.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("ring_deque_with_cursor test failed");
            $finish;
        end
    end

    // Offers one operation word, possibly after random idle cycles, and
    // returns at the edge at which it is accepted. Valid stays high so the
    // next word can follow back to back.
    task automatic send_word(input logic [OP_W-1:0] op, input logic [DIN_W-1:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'({data, op});
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
    endtask

    // Random data word with the all-zeros and all-ones extremes favored.
    function automatic logic [DIN_W-1:0] pick_word();
        case ($urandom_range(7))
            0: return '0;
            1: return WORD_ONES;
            default: return $urandom();
        endcase
    endfunction

    // Empty-store and no-cursor answers, both ends, cursor wrap in both
    // directions, popping the cursor entry, undefined codes and clear.
    task automatic test_directed();
        send_word(OP_POP_FRONT, pick_word());
        send_word(OP_POP_BACK, pick_word());
        send_word(OP_FIRST, pick_word());
        send_word(OP_LAST, pick_word());
        send_word(OP_NEXT, pick_word());
        send_word(OP_PREV, pick_word());
        send_word(OP_GET, pick_word());
        send_word(OP_PUSH_BACK, WORD_ONES);
        send_word(OP_PUSH_FRONT, '0);
        send_word(OP_PUSH_BACK, 32'hA5A5_5A5A);
        send_word(OP_FIRST, '0);
        send_word(OP_NEXT, '0);
        send_word(OP_NEXT, '0);
        send_word(OP_NEXT, '0);
        send_word(OP_PREV, '0);
        send_word(OP_LAST, '0);
        send_word(OP_GET, '0);
        send_word(OP_POP_BACK, '0);
        send_word(OP_GET, '0);
        send_word(OP_UNDEF_LO, WORD_ONES);
        send_word(OP_UNDEF_HI, WORD_ONES);
        send_word(OP_FIRST, '0);
        send_word(OP_CLEAR, WORD_ONES);
        send_word(OP_GET, '0);
        send_word(OP_POP_FRONT, '0);
    endtask

    // Fills past full from random ends, then drains past empty, with cursor
    // moves mixed in so the cursor walks a wrapped ring.
    task automatic test_fill_and_drain();
        send_word(OP_CLEAR, '0);
        for (int i = 0; i < DEPTH + 3; i++) begin
            send_word($urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT, pick_word());
            if ($urandom_range(3) == 0) begin
                send_word(t_op'($urandom_range(OP_GET, OP_FIRST)), pick_word());
            end
        end
        for (int i = 0; i < DEPTH + 3; i++) begin
            send_word($urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT, pick_word());
            if ($urandom_range(3) == 0) begin
                send_word(t_op'($urandom_range(OP_GET, OP_FIRST)), pick_word());
            end
        end
    endtask

    // Random operation mix, slightly biased toward pushes so the fill level
    // wanders; clear and undefined codes appear rarely.
    task automatic test_random_mix(input int n_words);
        int               r;
        logic [OP_W-1:0]  op;
        for (int i = 0; i < n_words; i++) begin
            r = $urandom_range(99);
            if (r < 15) begin
                op = OP_PUSH_FRONT;
            end else if (r < 30) begin
                op = OP_PUSH_BACK;
            end else if (r < 40) begin
                op = OP_POP_FRONT;
            end else if (r < 50) begin
                op = OP_POP_BACK;
            end else if (r < 58) begin
                op = OP_FIRST;
            end else if (r < 66) begin
                op = OP_LAST;
            end else if (r < 78) begin
                op = OP_NEXT;
            end else if (r < 90) begin
                op = OP_PREV;
            end else if (r < 96) begin
                op = OP_GET;
            end else if (r < 97) begin
                op = OP_CLEAR;
            end else begin
                op = OP_W'($urandom_range(OP_UNDEF_HI, OP_UNDEF_LO));
            end
            send_word(op, pick_word());
        end
    endtask

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_directed();
        test_random_mix(100);

        send_idle_pct = 46;
        recv_stall_pct = 0;
        test_fill_and_drain();
        test_random_mix(100);

        send_idle_pct = 0;
        recv_stall_pct = 46;
        test_random_mix(100);
        test_fill_and_drain();

        send_idle_pct = 10;
        recv_stall_pct = 10;
        test_random_mix(100);

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
        if (err_count == 0) begin
            $display("ring_deque_with_cursor test passed");
        end else begin
            $display("ring_deque_with_cursor test failed");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/rdq_pkg.sv
hw/rtl/rdq_store.sv
hw/rtl/ring_deque_with_cursor.sv
dv/tb_ring_deque_with_cursor.sv
